FILE: src/ptnc_pkg.sv
// ----------------------------------------------------------------------------
// ptnc_pkg: shared types and constants
// Command codes, count and distance widths, and the distance beat struct
// passed from the distance stage to the search control.
// ----------------------------------------------------------------------------
package ptnc_pkg;

  localparam int CMD_W  = 3;
  localparam int CNT_W  = 9;
  localparam int COMP_W = 8;
  localparam int ENT_W  = 32;
  localparam int DIST_W = 18;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MAP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd4;

  localparam logic [DIST_W-1:0] DIST_START = 18'h30000;

  typedef struct packed {
    logic              valid;
    logic              match;
    logic [CNT_W-1:0]  tag;
    logic [DIST_W-1:0] sq_dist;
  } dist_res_t;

endpackage

FILE: src/palette_table_nearest_color_core.sv
// ----------------------------------------------------------------------------
// palette_table_nearest_color_core: palette store with nearest-color search
// Holds RGB plus flag entries and a live count; serves write, read, map,
// resize and nearest-color search commands, one result beat per item.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   cmd index red green blue flags
//                                         new_count last_of_run
// out      output     out_valid/out_ready status out_red out_green out_blue
//                                         out_flags nearest_index run_done
//
// write, bad command and rejected items: no memory read; read and map: one memory read
// search: at most live count memory reads, one memory read per cycle, ending
//   early on an exact match
// resize: grown entries are zeroed, one memory write per cycle
// reset clears the live count and control; the store is not cleared
// in_ready is low while an item is at work; a stalled result beat holds
// in the output register while the next item is taken
// ----------------------------------------------------------------------------
module palette_table_nearest_color_core
  import ptnc_pkg::*;
#(
  parameter int PAL_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [7:0]        index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        flags,
  input  logic [CNT_W-1:0]  new_count,
  input  logic              last_of_run,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_flags,
  output logic [7:0]        nearest_index,
  output logic              run_done
);

  localparam int AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  ctr;
  logic [CNT_W-1:0]  end_cnt;
  logic              iss_on;
  logic              v1;
  logic [CNT_W-1:0]  t1;
  logic [DIST_W-1:0] best;
  logic [CMD_W-1:0]  req_cmd;
  logic [7:0]        req_red, req_green, req_blue;

  logic              res_status;
  logic [7:0]        res_red, res_green, res_blue, res_flags, res_near;
  logic              res_last;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;
  dist_res_t         dres;

  logic              accept;
  logic              index_ok;
  logic              count_zero;
  logic              grow_bad;
  logic [CNT_W-1:0]  last_idx;
  logic [31:0]       idx_wide, ctr_wide;
  logic [AW-1:0]     idx_addr, ctr_addr;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign index_ok   = {1'b0, index} < live_count;
  assign count_zero = (live_count == '0);
  assign grow_bad   = 32'(new_count) > PAL_DEPTH;
  assign last_idx   = live_count - CNT_W'(1);
  assign idx_wide   = 32'(index);
  assign ctr_wide   = 32'(ctr);
  assign idx_addr   = idx_wide[AW-1:0];
  assign ctr_addr   = ctr_wide[AW-1:0];

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx_addr;
    raddr = idx_addr;
    wdata = {flags, blue, green, red};
    if (accept && (cmd == CMD_WRITE) && index_ok) begin
      we = 1'b1;
    end
    if (accept && (cmd == CMD_READ) && index_ok) begin
      re = 1'b1;
    end
    if (accept && (cmd == CMD_MAP) && !count_zero) begin
      re = 1'b1;
      raddr = index_ok ? idx_addr : '0;
    end
    if ((state == S_SRCH) && iss_on) begin
      re = 1'b1;
      raddr = ctr_addr;
    end
    if (state == S_ZERO) begin
      we = 1'b1;
      waddr = ctr_addr;
      wdata = '0;
    end
  end

  ptnc_ram #(
    .DEPTH (PAL_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ptnc_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .valid (v1),
    .tag   (t1),
    .entry (rdata),
    .red   (req_red),
    .green (req_green),
    .blue  (req_blue),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      iss_on     <= 1'b0;
      v1         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      v1 <= (state == S_SRCH) && iss_on;
      t1 <= ctr;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_cmd    <= cmd;
            req_red    <= red;
            req_green  <= green;
            req_blue   <= blue;
            res_status <= 1'b0;
            res_red    <= '0;
            res_green  <= '0;
            res_blue   <= '0;
            res_flags  <= '0;
            res_near   <= '0;
            res_last   <= last_of_run;
            best       <= DIST_START;
            ctr        <= '0;
            state      <= S_DONE;
            unique case (cmd)
              CMD_WRITE: begin
                res_status <= !index_ok;
              end
              CMD_READ: begin
                res_status <= !index_ok;
                if (index_ok) begin
                  state <= S_RD;
                end
              end
              CMD_MAP: begin
                res_status <= count_zero;
                if (!count_zero) begin
                  state <= S_RD;
                end
              end
              CMD_SEARCH: begin
                res_status <= count_zero;
                if (!count_zero) begin
                  iss_on <= 1'b1;
                  state  <= S_SRCH;
                end
              end
              CMD_RESIZE: begin
                res_status <= grow_bad;
                if (!grow_bad) begin
                  live_count <= new_count;
                  ctr        <= live_count;
                  end_cnt    <= new_count;
                  if (live_count < new_count) begin
                    state <= S_ZERO;
                  end
                end
              end
              default: begin
                res_status <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          res_red   <= rdata[7:0];
          res_green <= rdata[15:8];
          res_blue  <= rdata[23:16];
          if (req_cmd == CMD_READ) begin
            res_flags <= rdata[31:24];
          end
          state <= S_DONE;
        end
        S_SRCH: begin
          if (iss_on) begin
            ctr <= ctr + CNT_W'(1);
            if (ctr == last_idx) begin
              iss_on <= 1'b0;
            end
          end
          if (dres.valid) begin
            if (dres.match) begin
              res_near <= dres.tag[7:0];
              iss_on   <= 1'b0;
              state    <= S_DONE;
            end else begin
              if (dres.sq_dist < best) begin
                best     <= dres.sq_dist;
                res_near <= dres.tag[7:0];
              end
              if (dres.tag == last_idx) begin
                iss_on <= 1'b0;
                state  <= S_DONE;
              end
            end
          end
        end
        S_ZERO: begin
          ctr <= ctr + CNT_W'(1);
          if (ctr == end_cnt - CNT_W'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            out_red       <= res_red;
            out_green     <= res_green;
            out_blue      <= res_blue;
            out_flags     <= res_flags;
            nearest_index <= res_near;
            run_done      <= res_last;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/ptnc_ram.sv
// ----------------------------------------------------------------------------
// ptnc_ram: palette entry store
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ptnc_ram
  import ptnc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ENT_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [ENT_W-1:0] rdata
);

  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ptnc_dist.sv
// ----------------------------------------------------------------------------
// ptnc_dist: registered color distance stage
// Squared RGB distance and exact-match flag of one entry against the
// search color, with the entry position carried along as a tag.
// ----------------------------------------------------------------------------
module ptnc_dist
  import ptnc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic [CNT_W-1:0]  tag,
  input  logic [ENT_W-1:0]  entry,
  input  logic [COMP_W-1:0] red,
  input  logic [COMP_W-1:0] green,
  input  logic [COMP_W-1:0] blue,
  output dist_res_t         res
);

  logic [COMP_W-1:0]   dr, dg, db;
  logic [2*COMP_W-1:0] sr, sg, sb;
  logic [DIST_W-1:0]   sum;
  logic                match;

  always_comb begin
    dr = (entry[7:0] > red) ? entry[7:0] - red : red - entry[7:0];
    dg = (entry[15:8] > green) ? entry[15:8] - green : green - entry[15:8];
    db = (entry[23:16] > blue) ? entry[23:16] - blue : blue - entry[23:16];
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    sum = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    match = (entry[7:0] == red) && (entry[15:8] == green) && (entry[23:16] == blue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= valid;
    end
    res.match   <= match;
    res.tag     <= tag;
    res.sq_dist <= sum;
  end

endmodule
